// File: rtl/core/prr_pkg.sv
// Package for the polyphase rational resampler: defaults, codes and shared types.
package prr_pkg;

    // Default parameter values
    localparam int MAX_TAPS_DEF    = 256;
    localparam int MAX_RATE_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration space
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int UP_W       = 6;
    localparam int DOWN_W     = 6;
    localparam int TAPS_W     = 9;
    localparam int CIDX_W     = 8;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_UP_FACTOR   = 2'd0;
    localparam logic [1:0] REG_DOWN_FACTOR = 2'd1;
    localparam logic [1:0] REG_TAP_COUNT   = 2'd2;

    // Item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;      // zero the accumulator
        logic tap_valid;  // a tap read was issued this cycle
        logic sample_ok;  // delay line entry has been written
    } mac_ctrl_t;

endpackage

// File: rtl/core/prr_ram.sv
// Generic simple dual-port RAM with registered read.
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/prr_mac.sv
// Shared multiply-accumulate unit with Q1.15 round and saturate.
module prr_mac #(
    parameter int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_TAPS    = prr_pkg::MAX_TAPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prr_pkg::mac_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0] coef_data,
    input  logic [SAMPLE_BITS-1:0] sample_data,
    output logic                   busy,
    output logic [SAMPLE_BITS-1:0] result
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam bit SAT   = (PW + AW) > 64;
    localparam int ACC_W = SAT ? 64 : (PW + AW);
    localparam int FB    = SAMPLE_BITS - 1;

    localparam logic signed [ACC_W:0] LIM    = (ACC_W + 1)'(64'sd1 <<< 62);
    localparam logic signed [ACC_W:0] RND    = (ACC_W + 1)'(1) <<< (FB - 1);
    localparam logic signed [ACC_W:0] OUT_HI = (ACC_W + 1)'((64'sd1 <<< FB) - 64'sd1);
    localparam logic signed [ACC_W:0] OUT_LO = -OUT_HI - (ACC_W + 1)'(1);

    logic                    s1_vld_reg;
    logic                    s1_ok_reg;
    logic                    s2_vld_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [ACC_W:0]   quot;
    logic [SAMPLE_BITS-1:0]  sample_sel;

    // Stage 1 lines up with the RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s1_ok_reg  <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctrl.tap_valid;
            s1_ok_reg  <= ctrl.sample_ok;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Unwritten delay line entries read as zero
    assign sample_sel = s1_ok_reg ? sample_data : '0;
    assign prod_next  = $signed(coef_data) * $signed(sample_sel);
    assign sum        = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(prod_reg);

    always_comb
    begin
        acc_next = sum[ACC_W-1:0];
        if (SAT)
        begin
            if (sum > LIM)
            begin
                acc_next = LIM[ACC_W-1:0];
            end
            else if (sum < -LIM)
            begin
                acc_next = ACC_W'(-LIM);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round half up, then clip to the output range
    assign rnd_sum = (ACC_W + 1)'(acc_reg) + RND;
    assign quot    = rnd_sum >>> FB;

    always_comb
    begin
        if (quot > OUT_HI)
        begin
            result = OUT_HI[SAMPLE_BITS-1:0];
        end
        else if (quot < OUT_LO)
        begin
            result = OUT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = quot[SAMPLE_BITS-1:0];
        end
    end

    assign busy = s1_vld_reg || s2_vld_reg;

endmodule

// File: rtl/core/polyphase_rational_resampler.sv
// Top level of the polyphase rational resampler: config, sequencer, memories, output register.
// Each result is computed one tap per cycle on the single shared multiplier; a new sample
// is taken only once every result of the previous one has been loaded into the output register.
// s_tready is high only while the sequencer is idle.
// Reset (rst_n, async, active low): U = D = tap_count = 1, phase and write pointer zero, delay
// line reads as zero through a fill count; coefficients are undefined until written.
module polyphase_rational_resampler #(
    parameter int MAX_TAPS    = prr_pkg::MAX_TAPS_DEF,
    parameter int MAX_RATE    = prr_pkg::MAX_RATE_DEF,
    parameter int SAMPLE_BITS = prr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: sample_in, coef_index, coef_value, zero pad
    input  logic [((2*SAMPLE_BITS+prr_pkg::CIDX_W+7)/8)*8-1:0] s_tdata,
    // s_tuser: operation
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, low bit up: sample_out, zero pad
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
    output logic                               m_tlast,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prr_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prr_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_TAPS);
    localparam int FW    = $clog2(MAX_TAPS + 1);
    localparam int KW    = $clog2(MAX_TAPS + MAX_RATE + 1);
    localparam int TW    = $clog2(2 * MAX_RATE);
    localparam int OUT_W = ((SB + 7) / 8) * 8;
    localparam int CI_W  = prr_pkg::CIDX_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [prr_pkg::UP_W-1:0]   up_reg;
    logic [prr_pkg::DOWN_W-1:0] down_reg;
    logic [prr_pkg::TAPS_W-1:0] taps_reg;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[prr_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= prr_pkg::UP_W'(1);
            down_reg <= prr_pkg::DOWN_W'(1);
            taps_reg <= prr_pkg::TAPS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                prr_pkg::REG_UP_FACTOR:   up_reg   <= pwdata[prr_pkg::UP_W-1:0];
                prr_pkg::REG_DOWN_FACTOR: down_reg <= pwdata[prr_pkg::DOWN_W-1:0];
                prr_pkg::REG_TAP_COUNT:   taps_reg <= pwdata[prr_pkg::TAPS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            prr_pkg::REG_UP_FACTOR:   prdata = prr_pkg::CFG_DATA_W'(up_reg);
            prr_pkg::REG_DOWN_FACTOR: prdata = prr_pkg::CFG_DATA_W'(down_reg);
            prr_pkg::REG_TAP_COUNT:   prdata = prr_pkg::CFG_DATA_W'(taps_reg);
            default:                  prdata = '0;
        endcase
    end

    // Factors and tap count clipped to their usable ranges (zero acts as one)
    logic [TW-1:0] u_eff;
    logic [TW-1:0] d_eff;
    logic [KW-1:0] taps_eff;

    assign u_eff = (up_reg == '0) ? TW'(1) :
                   (32'(up_reg) > MAX_RATE) ? TW'(MAX_RATE) : TW'(up_reg);
    assign d_eff = (down_reg == '0) ? TW'(1) :
                   (32'(down_reg) > MAX_RATE) ? TW'(MAX_RATE) : TW'(down_reg);
    assign taps_eff = (taps_reg == '0) ? KW'(1) :
                      (32'(taps_reg) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(taps_reg);

    // ---------------------------------------------------------------
    // Input unpacking
    // ---------------------------------------------------------------
    logic [SB-1:0]   sample_in;
    logic [CI_W-1:0] coef_index;
    logic [SB-1:0]   coef_value;

    assign sample_in  = s_tdata[SB-1:0];
    assign coef_index = s_tdata[SB+CI_W-1:SB];
    assign coef_value = s_tdata[2*SB+CI_W-1:SB+CI_W];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [1:0]    state_reg, state_next;
    logic [TW-1:0] phase_reg, phase_next;   // n*D - j*U for the next output
    logic [TW-1:0] t_reg, t_next;           // phase of the output in progress
    logic [KW-1:0] k_reg, k_next;           // coefficient index
    logic [AW-1:0] pos_reg, pos_next;       // delay line read position
    logic [AW-1:0] base_reg, base_next;     // position of the newest sample
    logic [AW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;     // entries written since reset

    logic          in_xfer;
    logic          sample_xfer;
    logic          coef_xfer;
    logic          out_free;
    logic          out_load;
    logic          more;
    logic [TW-1:0] t_plus_d;
    logic [AW-1:0] pos_dec;
    logic          mac_busy;
    logic [SB-1:0] mac_result;
    prr_pkg::mac_ctrl_t mac_ctrl;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_xfer     = s_tvalid && s_tready;
    assign sample_xfer = in_xfer && (s_tuser == prr_pkg::OP_SAMPLE);
    assign coef_xfer   = in_xfer && (s_tuser == prr_pkg::OP_COEF);
    assign t_plus_d    = t_reg + d_eff;
    assign more        = (t_plus_d < u_eff);
    assign pos_dec     = (pos_reg == '0) ? AW'(MAX_TAPS - 1) : pos_reg - AW'(1);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        base_next  = base_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        out_load   = 1'b0;
        mac_ctrl   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    wp_next   = (32'(wp_reg) == MAX_TAPS - 1) ? '0 : wp_reg + AW'(1);
                    fill_next = (32'(fill_reg) < MAX_TAPS) ? fill_reg + FW'(1) : fill_reg;
                    base_next = wp_reg;
                    if (phase_reg < u_eff)
                    begin
                        t_next         = phase_reg;
                        k_next         = KW'(phase_reg);
                        pos_next       = wp_reg;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_ISSUE;
                    end
                    else
                    begin
                        // phase already past this sample: no output
                        phase_next = phase_reg - u_eff;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (k_reg < taps_eff)
                begin
                    mac_ctrl.tap_valid = 1'b1;
                    mac_ctrl.sample_ok = (FW'(pos_reg) < fill_reg);
                    k_next             = k_reg + KW'(u_eff);
                    pos_next           = pos_dec;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (more)
                    begin
                        t_next         = t_plus_d;
                        k_next         = KW'(t_plus_d);
                        pos_next       = base_reg;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_ISSUE;
                    end
                    else
                    begin
                        phase_next = t_plus_d - u_eff;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        k_reg    <= k_next;
        pos_reg  <= pos_next;
        base_reg <= base_next;
    end

    // ---------------------------------------------------------------
    // Memories and shared MAC
    // ---------------------------------------------------------------
    logic [SB-1:0] coef_rd;
    logic [SB-1:0] delay_rd;

    prr_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_xfer && (32'(coef_index) < MAX_TAPS)),
        .wr_addr (AW'(coef_index)),
        .wr_data (coef_value),
        .rd_en   (mac_ctrl.tap_valid),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (coef_rd)
    );

    prr_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (sample_xfer),
        .wr_addr (wp_reg),
        .wr_data (sample_in),
        .rd_en   (mac_ctrl.tap_valid),
        .rd_addr (pos_reg),
        .rd_data (delay_rd)
    );

    prr_mac #(
        .SAMPLE_BITS (SB),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mac_ctrl),
        .coef_data   (coef_rd),
        .sample_data (delay_rd),
        .busy        (mac_busy),
        .result      (mac_result)
    );

    // ---------------------------------------------------------------
    // Output register: holds a result while the sequencer goes on
    // ---------------------------------------------------------------
    logic          out_valid_reg;
    logic [SB-1:0] out_data_reg;
    logic          out_last_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
            out_last_reg <= !more;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // Phase left between samples stays below MAX_RATE, the largest decimation step
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (32'(phase_reg) < MAX_RATE))
        else $error("phase out of range while idle");

    // Coefficient index stays inside the memory whenever a tap is read
    a_tap_index: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctrl.tap_valid |-> (32'(k_reg) < MAX_TAPS))
        else $error("tap read beyond coefficient memory");

    // A result is only taken once the MAC pipeline has drained
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !mac_busy)
        else $error("result emitted with MAC busy");

    // Fill count saturates at the delay line depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_TAPS)
        else $error("fill count overflow");

    // Input is held off while an output is being computed
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!mac_busy && !mac_ctrl.tap_valid))
        else $error("input ready during computation");
`endif

endmodule

// File: tb/prr_checker.sv
// Checker for the polyphase rational resampler: tracks config, predicts results, compares.
module prr_checker
    import prr_pkg::*;
#(
    parameter int SDATA_W = ((2*SAMPLE_BITS_DEF+CIDX_W+7)/8)*8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [SDATA_W-1:0]    s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_DEPTH = 256;
    localparam int RATE_MAX  = 32;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } resampled_t;

    logic signed [15:0] coef_mem [TAP_DEPTH];
    logic signed [15:0] history  [TAP_DEPTH];
    logic [7:0]         wr_ptr;
    logic [5:0]         phase;
    logic [5:0]         up_reg;
    logic [5:0]         down_reg;
    logic [8:0]         taps_reg;
    resampled_t         resampled_q [$];
    int                 err_cnt;

    function automatic int clamp_range(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Q2.30 sum back to Q1.15: round half up, then saturate
    function automatic logic signed [15:0] round_q15(input longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767)
            return 16'sh7FFF;
        if (q < -32768)
            return 16'sh8000;
        return q[15:0];
    endfunction

    // Shift one sample in and queue every output whose newest input it is.
    // The accumulator limit of 2^62 is out of reach at 256 taps, so a plain sum is exact.
    task automatic filter_sample(input logic signed [15:0] x);
        int         u;
        int         d;
        int         ntaps;
        int         t;
        int         k;
        int         n;
        longint     acc;
        logic [7:0] pos;
        resampled_t r;
        u     = clamp_range(up_reg, RATE_MAX);
        d     = clamp_range(down_reg, RATE_MAX);
        ntaps = clamp_range(taps_reg, TAP_DEPTH);
        history[wr_ptr] = x;
        t = phase;
        n = 0;
        while (t < u && n < RATE_MAX)
        begin
            acc = 0;
            pos = wr_ptr;
            for (k = t; k < ntaps; k += u)
            begin
                acc += longint'(coef_mem[k]) * longint'(history[pos]);
                pos = pos - 8'd1;
            end
            r.value = round_q15(acc);
            r.last  = (t + d >= u) || (n == RATE_MAX - 1);
            resampled_q = {resampled_q, r};
            n++;
            t += d;
        end
        phase  = (t >= u) ? 6'(t - u) : 6'd0;
        wr_ptr = wr_ptr + 8'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        resampled_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_DEPTH; i++)
            begin
                coef_mem[i] = '0;
                history[i]  = '0;
            end
            wr_ptr   = '0;
            phase    = '0;
            up_reg   = 6'd1;
            down_reg = 6'd1;
            taps_reg = 9'd1;
            err_cnt  = 0;
            resampled_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_UP_FACTOR:   up_reg   = pwdata[5:0];
                    REG_DOWN_FACTOR: down_reg = pwdata[5:0];
                    REG_TAP_COUNT:   taps_reg = pwdata[8:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_COEF)
                    coef_mem[s_tdata[23:16]] = s_tdata[39:24];
                else
                    filter_sample(s_tdata[15:0]);
            end

            if (m_tvalid && m_tready)
            begin
                if (resampled_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("%0t: result with nothing expected: sample_out %0d last %0b",
                                 $realtime, $signed(m_tdata), m_tlast);
                    err_cnt++;
                end
                else
                begin
                    r = resampled_q.pop_front();
                    if (m_tdata !== r.value || m_tlast !== r.last)
                    begin
                        if (err_cnt < 10)
                            $display("%0t: mismatch: expected sample_out %0d last %0b, got %0d last %0b",
                                     $realtime, r.value, r.last, $signed(m_tdata), m_tlast);
                        err_cnt++;
                    end
                end
            end

            errors  <= err_cnt;
            pending <= resampled_q.size();
        end
    end

endmodule

// File: tb/tb_polyphase_rational_resampler.sv
// Testbench top for the polyphase rational resampler: clock, reset, stimulus and verdict.
module tb_polyphase_rational_resampler;
    timeunit 1ns;
    timeprecision 1ps;
    import prr_pkg::*;

    localparam int SDATA_W        = ((2*SAMPLE_BITS_DEF+CIDX_W+7)/8)*8;
    // Longest quiet stretch of a correct run: the receiver hold-off, or a 256-tap
    // result, or the settle pause; taken several times over.
    localparam int WATCHDOG_LIMIT = 4000;
    // Longer than the worst single result; covers a sample still in flight with no output
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS    = 25;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata, low bit up: sample_in[15:0], coef_index[23:16], coef_value[39:24]
    logic [SDATA_W-1:0]     s_tdata  = '0;
    // s_tuser: operation (OP_SAMPLE / OP_COEF)
    logic                   s_tuser  = OP_SAMPLE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata, low bit up: sample_out[15:0]
    logic [15:0]            m_tdata;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr    = '0;
    logic [CFG_DATA_W-1:0]  pwdata   = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     errors;
    int                     pending;
    int                     quiet_cycles = 0;
    // calm: no random idling on either side; hold_off_req: one long receiver stall
    bit                     calm         = 1'b0;
    bit                     hold_off_req = 1'b0;

    always #2 clk = ~clk;

    polyphase_rational_resampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    prr_checker #(.SDATA_W(SDATA_W)) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Watchdog: any transfer on either stream or the config port restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_polyphase_rational_resampler: done, errors");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a single long hold-off on request.
    // While held, the sequencer cannot drain, so s_tready drops with the sender still offering.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Mostly full-range random, sometimes an extreme or a value next to zero
    function automatic logic [15:0] pick_q15();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item; returns in the time step of the edge that took it.
    task automatic offer_item(input logic op, input logic [15:0] smp,
                              input logic [7:0] idx, input logic [15:0] cval);
        while (!calm && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cval, idx, smp};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Unused fields carry noise so every bit of tdata toggles
    task automatic send_sample(input logic [15:0] smp);
        offer_item(OP_SAMPLE, smp, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(input logic [7:0] idx, input logic [15:0] cval);
        offer_item(OP_COEF, 16'($urandom), idx, cval);
    endtask

    // Drop valid, drain all expected results, then let any silent work finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then back to idle
    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rates(input int up, input int down, input int taps);
        settle();
        write_reg(REG_UP_FACTOR, up);
        write_reg(REG_DOWN_FACTOR, down);
        write_reg(REG_TAP_COUNT, taps);
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rates (U = D = 1, one tap): full-scale products, rounding,
        // and -1.0 squared saturating to the positive limit
        send_coef(8'd0, 16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_coef(8'd0, 16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);

        // Zero factors act as 1; four taps summing past the negative limit
        set_rates(0, 0, 4);
        send_coef(8'd1, 16'h8000);
        send_coef(8'd2, 16'h8000);
        send_coef(8'd3, 16'h7FFF);
        repeat (4) send_sample(16'h7FFF);

        // Oversized U clamps to 32: each sample fans out to the full 32 results;
        // tap count zero clamps to one
        set_rates(63, 0, 0);
        repeat (2) send_sample(pick_q15());

        // D beyond range clamps to 32: after the first, samples give no output
        set_rates(1, 40, 1);
        repeat (3) send_sample(pick_q15());

        // U drops below the held phase: first sample is silent, phase falls by U
        set_rates(28, 5, 3);
        repeat (3) send_sample(pick_q15());

        // Fill the whole coefficient memory so any tap count reads written entries
        for (int i = 0; i < 256; i++)
            send_coef(8'(i), pick_q15());

        // Random phases: fixed extremes first, then random rates with mostly short filters
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       set_rates(1, 1, 256);
                1:       set_rates(32, 1, 256);
                2:       set_rates(3, 2, 17);
                3:       set_rates(1, 32, 9);
                4:       set_rates(63, 33, 511);
                5:       set_rates($urandom_range(0, 63), $urandom_range(0, 12),
                                   $urandom_range(0, 300));
                default: set_rates($urandom_range(0, 12), $urandom_range(0, 63),
                                   $urandom_range(0, 64));
            endcase
            calm <= (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Heavy fan-out phase: stall the result side and let the input back up
                if (p == 1 && i == 20)
                    hold_off_req <= 1'b1;
                if ($urandom_range(99) < 15)
                    send_coef(8'($urandom), pick_q15());
                else
                    send_sample(pick_q15());
            end
        end

        calm <= 1'b0;
        settle();
        if (errors == 0 && pending == 0)
            $display("tb_polyphase_rational_resampler: done, clean");
        else
            $display("tb_polyphase_rational_resampler: done, errors");
        $finish;
    end

endmodule
